/* hw/rtl/ngh_pkg.sv */
package ngh_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int MAG_W           = SAMPLE_WIDTH - 1;
  localparam int COEFF_FRAC_BITS = 16;
  localparam int COEFF_W         = 16;
  localparam int ENV_FRAC        = 16;
  localparam int ENV_W           = MAG_W + ENV_FRAC;
  localparam int GAIN_FRAC       = 16;
  localparam int GAIN_W          = GAIN_FRAC + 1;
  localparam int THR_W           = 15;
  localparam int HOLD_W          = 16;
  localparam int TALLY_W         = 16;

  localparam int MUL_A_W = ((COEFF_W > SAMPLE_WIDTH) ? COEFF_W : SAMPLE_WIDTH) + 1;
  localparam int MUL_B_W = ((ENV_W > GAIN_W) ? ENV_W : GAIN_W) + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int APB_DW = 32;
  localparam int ADDR_W = 5;

  localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC{1'b0}}};

  typedef enum logic [2:0] {
    REG_OPEN_THR,
    REG_HYST,
    REG_ATTACK,
    REG_RELEASE,
    REG_HOLD,
    REG_CLOSED_GAIN
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENV_MUL,
    ST_ENV_UPD,
    ST_GATE,
    ST_GAIN_MUL,
    ST_GAIN_UPD,
    ST_OUT_MUL,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           block_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] gated_sample;
    logic                           gate_is_open;
    logic [TALLY_W-1:0]             openings;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [MAG_W-1:0]               mag;
    logic                           block_start;
  } work_item_t;

  typedef struct packed {
    logic [THR_W-1:0]   open_threshold;
    logic [THR_W-1:0]   hysteresis;
    logic [COEFF_W-1:0] attack_coeff;
    logic [COEFF_W-1:0] release_coeff;
    logic [HOLD_W-1:0]  hold_count;
    logic [GAIN_W-1:0]  closed_gain;
  } cfg_t;

endpackage

/* hw/rtl/ngh_fifo.sv */
module ngh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  // DEPTH must be at least 2
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr, rd;

  assign full_o    = (cnt_q == CNT_W'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign wr        = wr_en_i & ~full_o;
  assign rd        = rd_en_i & ~empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* hw/rtl/ngh_front.sv */
module ngh_front (
  input  logic                push_i,
  input  ngh_pkg::in_item_t   item_i,
  input  logic                q_full_i,
  output logic                full_o,
  output logic                q_push_o,
  output ngh_pkg::work_item_t q_item_o
);

  import ngh_pkg::*;

  logic [SAMPLE_WIDTH-1:0] neg;
  logic                    is_min;

  assign full_o   = q_full_i;
  assign q_push_o = push_i & ~q_full_i;

  // magnitude, most negative sample saturates
  assign neg    = ~item_i.sample + 1'b1;
  assign is_min = item_i.sample[SAMPLE_WIDTH-1] & (item_i.sample[MAG_W-1:0] == '0);

  always_comb begin
    q_item_o.sample      = item_i.sample;
    q_item_o.block_start = item_i.block_start;
    if (is_min) begin
      q_item_o.mag = '1;
    end else if (item_i.sample[SAMPLE_WIDTH-1]) begin
      q_item_o.mag = neg[MAG_W-1:0];
    end else begin
      q_item_o.mag = item_i.sample[MAG_W-1:0];
    end
  end

endmodule

/* hw/rtl/ngh_back.sv */
module ngh_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ngh_pkg::cfg_t       cfg_i,
  input  logic                head_valid_i,
  input  ngh_pkg::work_item_t head_i,
  output logic                head_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output ngh_pkg::out_item_t  res_item_o
);

  import ngh_pkg::*;

  localparam logic [PROD_W-1:0] COEFF_HALF = PROD_W'(2 ** (COEFF_FRAC_BITS - 1));
  localparam logic signed [PROD_W-1:0] OUT_HALF = PROD_W'(2 ** (GAIN_FRAC - 1));
  localparam logic signed [PROD_W-1:0] SAT_HI   = PROD_W'(2 ** (SAMPLE_WIDTH - 1) - 1);
  localparam logic signed [PROD_W-1:0] SAT_LO   = -PROD_W'(2 ** (SAMPLE_WIDTH - 1));

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
    return (g > GAIN_ONE) ? GAIN_ONE : g;
  endfunction

  back_state_e state_q, state_d;

  logic [ENV_W-1:0]   env_q, env_d;
  logic               gate_q, gate_d;
  logic [HOLD_W-1:0]  hold_q, hold_d;
  logic [GAIN_W-1:0]  gain_q, gain_d;
  logic [TALLY_W-1:0] tally_q, tally_d;

  logic signed [SAMPLE_WIDTH-1:0] sample_q, sample_d;
  logic [MAG_W-1:0]               mag_q, mag_d;
  logic signed [PROD_W-1:0]       prod_q, prod_d;
  logic                           up_q, up_d;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic [ENV_W-1:0]   absq, env_diff, env_step, open_q, close_q;
  logic [COEFF_W-1:0] env_coef, gain_coef;
  logic               env_up, gain_up, load;
  logic [THR_W-1:0]   close_thr;
  logic [GAIN_W-1:0]  gain_tgt, gain_diff, gain_step;
  logic [PROD_W-1:0]  rnd_c;
  logic signed [PROD_W-1:0]       out_rnd, out_shr;
  logic signed [SAMPLE_WIDTH-1:0] gated;

  // single shared multiplier
  assign mul_p = mul_a * mul_b;

  assign absq     = {mag_q, {ENV_FRAC{1'b0}}};
  assign env_up   = absq > env_q;
  assign env_coef = env_up ? cfg_i.attack_coeff : cfg_i.release_coeff;
  assign env_diff = env_up ? absq - env_q : env_q - absq;

  assign rnd_c     = $unsigned(prod_q) + COEFF_HALF;
  assign env_step  = rnd_c[COEFF_FRAC_BITS +: ENV_W];
  assign gain_step = rnd_c[COEFF_FRAC_BITS +: GAIN_W];

  assign open_q    = {cfg_i.open_threshold, {ENV_FRAC{1'b0}}};
  assign close_thr = (cfg_i.open_threshold > cfg_i.hysteresis) ?
                     cfg_i.open_threshold - cfg_i.hysteresis : '0;
  assign close_q   = {close_thr, {ENV_FRAC{1'b0}}};

  assign gain_tgt  = gate_q ? GAIN_ONE : clamp_gain(cfg_i.closed_gain);
  assign gain_coef = gate_q ? cfg_i.attack_coeff : cfg_i.release_coeff;
  assign gain_up   = gain_tgt >= gain_q;
  assign gain_diff = gain_up ? gain_tgt - gain_q : gain_q - gain_tgt;

  // round half up, then saturate
  assign out_rnd = prod_q + OUT_HALF;
  assign out_shr = out_rnd >>> GAIN_FRAC;

  always_comb begin
    if (out_shr > SAT_HI) begin
      gated = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (out_shr < SAT_LO) begin
      gated = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      gated = out_shr[SAMPLE_WIDTH-1:0];
    end
  end

  assign res_item_o.gated_sample = gated;
  assign res_item_o.gate_is_open = gate_q;
  assign res_item_o.openings     = tally_q;

  always_comb begin
    state_d    = state_q;
    env_d      = env_q;
    gate_d     = gate_q;
    hold_d     = hold_q;
    gain_d     = gain_q;
    tally_d    = tally_q;
    sample_d   = sample_q;
    mag_d      = mag_q;
    prod_d     = prod_q;
    up_d       = up_q;
    mul_a      = '0;
    mul_b      = '0;
    head_pop_o = 1'b0;
    res_push_o = 1'b0;
    load       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        load = head_valid_i;
      end
      ST_ENV_MUL: begin
        mul_a   = MUL_A_W'(env_coef);
        mul_b   = MUL_B_W'(env_diff);
        prod_d  = mul_p;
        up_d    = env_up;
        state_d = ST_ENV_UPD;
      end
      ST_ENV_UPD: begin
        env_d   = up_q ? env_q + env_step : env_q - env_step;
        state_d = ST_GATE;
      end
      ST_GATE: begin
        if (!gate_q) begin
          if (env_q >= open_q) begin
            gate_d = 1'b1;
            hold_d = cfg_i.hold_count;
            if (tally_q != '1) begin
              tally_d = tally_q + 1'b1;
            end
          end
        end else if (hold_q != '0) begin
          hold_d = hold_q - 1'b1;
        end else if (env_q < close_q) begin
          gate_d = 1'b0;
        end
        state_d = ST_GAIN_MUL;
      end
      ST_GAIN_MUL: begin
        mul_a   = MUL_A_W'(gain_coef);
        mul_b   = MUL_B_W'(gain_diff);
        prod_d  = mul_p;
        up_d    = gain_up;
        state_d = ST_GAIN_UPD;
      end
      ST_GAIN_UPD: begin
        gain_d  = up_q ? gain_q + gain_step : gain_q - gain_step;
        state_d = ST_OUT_MUL;
      end
      ST_OUT_MUL: begin
        mul_a   = MUL_A_W'(sample_q);
        mul_b   = MUL_B_W'(gain_q);
        prod_d  = mul_p;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (head_valid_i) begin
            load = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (load) begin
      head_pop_o = 1'b1;
      sample_d   = head_i.sample;
      mag_d      = head_i.mag;
      state_d    = ST_ENV_MUL;
      if (head_i.block_start) begin
        env_d   = '0;
        gate_d  = 1'b0;
        hold_d  = '0;
        tally_d = '0;
        gain_d  = clamp_gain(cfg_i.closed_gain);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      env_q   <= '0;
      gate_q  <= 1'b0;
      hold_q  <= '0;
      gain_q  <= '0;
      tally_q <= '0;
    end else begin
      state_q <= state_d;
      env_q   <= env_d;
      gate_q  <= gate_d;
      hold_q  <= hold_d;
      gain_q  <= gain_d;
      tally_q <= tally_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    mag_q    <= mag_d;
    prod_q   <= prod_d;
    up_q     <= up_d;
  end

endmodule

/* hw/rtl/noise_gate_hysteresis_hold_top.sv */
// Throughput is set by the three dependent products (envelope, gain, output) that share
// one multiplier in the back-end sequencer; it takes no new item before the last result
// is pushed, and a full result queue stalls it.
// Reset: asynchronous, active low; registers return to their defaults, state clears,
// both queues empty. No clearing pass.
module noise_gate_hysteresis_hold_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ngh_pkg::ADDR_W-1:0]  paddr,
  input  logic [ngh_pkg::APB_DW-1:0]  pwdata,
  output logic [ngh_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  input  logic                        push,
  output logic                        full,
  input  ngh_pkg::in_item_t           in_data_i,
  output logic                        empty,
  input  logic                        pop,
  output ngh_pkg::out_item_t          out_data_o
);

  import ngh_pkg::*;

  cfg_t       cfg_q;
  cfg_idx_e   reg_idx;
  logic       cfg_wr;

  logic       wq_push, wq_full, wq_empty, wq_pop;
  work_item_t wq_in, wq_out;
  logic       rq_push, rq_full;
  out_item_t  rq_in;

  assign pready  = 1'b1;
  assign reg_idx = cfg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_threshold <= THR_W'(328);
      cfg_q.hysteresis     <= '0;
      cfg_q.attack_coeff   <= COEFF_W'(41427);
      cfg_q.release_coeff  <= COEFF_W'(41427);
      cfg_q.hold_count     <= '0;
      cfg_q.closed_gain    <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_OPEN_THR:    cfg_q.open_threshold <= pwdata[THR_W-1:0];
        REG_HYST:        cfg_q.hysteresis     <= pwdata[THR_W-1:0];
        REG_ATTACK:      cfg_q.attack_coeff   <= pwdata[COEFF_W-1:0];
        REG_RELEASE:     cfg_q.release_coeff  <= pwdata[COEFF_W-1:0];
        REG_HOLD:        cfg_q.hold_count     <= pwdata[HOLD_W-1:0];
        REG_CLOSED_GAIN: cfg_q.closed_gain    <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OPEN_THR:    prdata = APB_DW'(cfg_q.open_threshold);
      REG_HYST:        prdata = APB_DW'(cfg_q.hysteresis);
      REG_ATTACK:      prdata = APB_DW'(cfg_q.attack_coeff);
      REG_RELEASE:     prdata = APB_DW'(cfg_q.release_coeff);
      REG_HOLD:        prdata = APB_DW'(cfg_q.hold_count);
      REG_CLOSED_GAIN: prdata = APB_DW'(cfg_q.closed_gain);
      default:         prdata = '0;
    endcase
  end

  ngh_front u_front (
    .push_i   (push),
    .item_i   (in_data_i),
    .q_full_i (wq_full),
    .full_o   (full),
    .q_push_o (wq_push),
    .q_item_o (wq_in)
  );

  ngh_fifo #(
    .WIDTH ($bits(work_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wq_push),
    .wr_data_i (wq_in),
    .rd_en_i   (wq_pop),
    .rd_data_o (wq_out),
    .full_o    (wq_full),
    .empty_o   (wq_empty)
  );

  ngh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (~wq_empty),
    .head_i       (wq_out),
    .head_pop_o   (wq_pop),
    .res_full_i   (rq_full),
    .res_push_o   (rq_push),
    .res_item_o   (rq_in)
  );

  ngh_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (rq_push),
    .wr_data_i (rq_in),
    .rd_en_i   (pop),
    .rd_data_o (out_data_o),
    .full_o    (rq_full),
    .empty_o   (empty)
  );

endmodule

/* hw/rtl/ngh_checker.sv */
module ngh_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [ngh_pkg::ADDR_W-1:0] paddr,
  input logic [ngh_pkg::APB_DW-1:0] pwdata,
  input logic [ngh_pkg::APB_DW-1:0] prdata,
  input logic                       push,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input ngh_pkg::out_item_t         out_data_o
);

  import ngh_pkg::*;

  logic [15:0] outstanding_q;
  logic        in_xfer, out_xfer;

  assign in_xfer  = push & ~full;
  assign out_xfer = pop & ~empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      outstanding_q <= outstanding_q + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      outstanding_q <= outstanding_q - 1'b1;
    end
  end

  // no result without an accepted input still owed one
  a_res_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (outstanding_q != '0))
    else $error("result with no outstanding input");

  a_res_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without transfer");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(out_data_o))
    else $error("waiting result changed");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (paddr[4:2] == REG_OPEN_THR)) ##1
    (psel && !pwrite && (paddr[4:2] == REG_OPEN_THR))
    |-> (prdata[THR_W-1:0] == $past(pwdata[THR_W-1:0])))
    else $error("open threshold readback mismatch");

endmodule

bind noise_gate_hysteresis_hold_top ngh_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);

/* sim/tb_noise_gate_hysteresis_hold_top.sv */
module tb_noise_gate_hysteresis_hold_top;
  import ngh_pkg::*;

  typedef enum int {
    FLOW_FREE,
    FLOW_TX_GAPS,
    FLOW_RX_STALLS,
    FLOW_BOTH
  } flow_e;

  class gate_scoreboard;
    logic [THR_W-1:0]   thr = 15'd328;
    logic [THR_W-1:0]   hyst = '0;
    logic [COEFF_W-1:0] atk = 16'd41427;
    logic [COEFF_W-1:0] rel = 16'd41427;
    logic [HOLD_W-1:0]  hold_cfg = '0;
    logic [GAIN_W-1:0]  gclosed = '0;

    logic [63:0]        env = '0;
    logic [63:0]        gain = '0;
    logic               gate = 1'b0;
    logic [HOLD_W-1:0]  hold_left = '0;
    logic [TALLY_W-1:0] tally = '0;

    out_item_t          gated_q[$];
    int                 errors = 0;

    function void flag(string what, longint e, longint a);
      errors++;
      if (errors <= 10) $display("%s: expected %0d, got %0d", what, e, a);
    endfunction

    function void write_reg(cfg_idx_e idx, logic [APB_DW-1:0] v);
      case (idx)
        REG_OPEN_THR:    thr = v[THR_W-1:0];
        REG_HYST:        hyst = v[THR_W-1:0];
        REG_ATTACK:      atk = v[COEFF_W-1:0];
        REG_RELEASE:     rel = v[COEFF_W-1:0];
        REG_HOLD:        hold_cfg = v[HOLD_W-1:0];
        REG_CLOSED_GAIN: gclosed = v[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [APB_DW-1:0] reg_value(cfg_idx_e idx);
      case (idx)
        REG_OPEN_THR:    return APB_DW'(thr);
        REG_HYST:        return APB_DW'(hyst);
        REG_ATTACK:      return APB_DW'(atk);
        REG_RELEASE:     return APB_DW'(rel);
        REG_HOLD:        return APB_DW'(hold_cfg);
        REG_CLOSED_GAIN: return APB_DW'(gclosed);
        default:         return '0;
      endcase
    endfunction

    function logic [63:0] floor_gain();
      return (gclosed > 17'd65536) ? 64'd65536 : 64'(gclosed);
    endfunction

    // one smoothing step toward tgt, rounded half up, never overshoots
    function logic [63:0] glide(logic [63:0] x, logic [63:0] tgt, logic [63:0] c);
      if (tgt >= x) return x + ((c * (tgt - x) + 64'd32768) >> COEFF_FRAC_BITS);
      return x - ((c * (x - tgt) + 64'd32768) >> COEFF_FRAC_BITS);
    endfunction

    function int pending();
      return gated_q.size();
    endfunction

    function void note_input(in_item_t it);
      logic signed [63:0] s;
      logic signed [63:0] prod;
      logic signed [63:0] res;
      logic [63:0]        mag;
      logic [63:0]        absq;
      logic [63:0]        openq;
      logic [63:0]        closeq;
      logic [63:0]        t64;
      logic [63:0]        h64;
      out_item_t          exp_item;
      if (it.block_start) begin
        env = '0;
        gate = 1'b0;
        hold_left = '0;
        gain = floor_gain();
        tally = '0;
      end
      s = it.sample;
      mag = (s < 0) ? -s : s;
      if (mag > 64'd32767) mag = 64'd32767;
      absq = mag << ENV_FRAC;
      env = glide(env, absq, (absq > env) ? 64'(atk) : 64'(rel));

      t64 = 64'(thr);
      h64 = 64'(hyst);
      openq = t64 << ENV_FRAC;
      closeq = (t64 > h64) ? ((t64 - h64) << ENV_FRAC) : 64'd0;
      if (!gate) begin
        if (env >= openq) begin
          gate = 1'b1;
          hold_left = hold_cfg;
          if (tally != 16'hFFFF) tally++;
        end
      end else if (hold_left != 0) begin
        hold_left--;
      end else if (env < closeq) begin
        gate = 1'b0;
      end

      gain = glide(gain, gate ? 64'd65536 : floor_gain(), gate ? 64'(atk) : 64'(rel));

      prod = s * $signed(gain);
      res = (prod + 64'sd32768) >>> 16;
      if (res > 64'sd32767) res = 64'sd32767;
      if (res < -64'sd32768) res = -64'sd32768;
      exp_item.gated_sample = res[SAMPLE_WIDTH-1:0];
      exp_item.gate_is_open = gate;
      exp_item.openings = tally;
      gated_q.push_back(exp_item);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (gated_q.size() == 0) begin
        flag("unexpected result, gated_sample", 0, got.gated_sample);
        return;
      end
      want = gated_q.pop_front();
      if (got.gated_sample !== want.gated_sample)
        flag("gated_sample", want.gated_sample, got.gated_sample);
      if (got.gate_is_open !== want.gate_is_open)
        flag("gate_is_open", want.gate_is_open, got.gate_is_open);
      if (got.openings !== want.openings)
        flag("openings", want.openings, got.openings);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                push = 1'b0;
  logic                full;
  in_item_t            in_data_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  out_item_t           out_data_o;

  gate_scoreboard      sb = new();
  flow_e               idle_mode = FLOW_FREE;

  noise_gate_hysteresis_hold_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .push      (push),
    .full      (full),
    .in_data_i (in_data_i),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    if (push && !full) sb.note_input(in_data_i);
    if (pop && !empty) sb.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= ((idle_mode == FLOW_RX_STALLS) ? 56 :
                                     (idle_mode == FLOW_BOTH) ? 32 : 0));
    end
  end

  // write a register, then read it back
  task automatic reg_rw(cfg_idx_e idx, logic [APB_DW-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, v);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== sb.reg_value(idx)) sb.flag("register readback", sb.reg_value(idx), prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(int thr, int hyst, int atk, int rel, int hold, int cg);
    reg_rw(REG_OPEN_THR, thr);
    reg_rw(REG_HYST, hyst);
    reg_rw(REG_ATTACK, atk);
    reg_rw(REG_RELEASE, rel);
    reg_rw(REG_HOLD, hold);
    reg_rw(REG_CLOSED_GAIN, cg);
  endtask

  task automatic send_item(logic signed [SAMPLE_WIDTH-1:0] smp, logic bs);
    in_item_t it;
    it.sample = smp;
    it.block_start = bs;
    while ($urandom_range(99) < ((idle_mode == FLOW_TX_GAPS) ? 56 :
                                 (idle_mode == FLOW_BOTH) ? 32 : 0)) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  initial begin
    int thr;
    int hyst;
    int atk;
    int rel;
    int hold;
    int cg;
    int seg_left;
    int loudness;
    int amp;
    logic signed [SAMPLE_WIDTH-1:0] smp;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: gain starts at zero, no block start yet
    send_item(16'sd100, 1'b0);
    send_item(16'sd32767, 1'b0);
    send_item(-16'sd32768, 1'b0);
    send_item(-16'sd32768, 1'b0);
    send_item(-16'sd1, 1'b0);
    send_item(16'sd1, 1'b0);
    send_item(16'sd0, 1'b0);
    send_item(16'sd0, 1'b1);
    send_item(16'sd32767, 1'b1);
    drain();

    // zero threshold, hysteresis above threshold, fastest coefficients,
    // longest hold, closed gain above one
    apply_cfg(0, 32767, 65535, 65535, 65535, 131071);
    send_item(16'sd0, 1'b1);
    send_item(-16'sd32768, 1'b0);
    send_item(16'sd32767, 1'b0);
    send_item(16'sd0, 1'b0);
    send_item(-16'sd1, 1'b0);
    send_item(16'sd12345, 1'b1);
    send_item(-16'sd32767, 1'b0);
    drain();

    // coefficients frozen, highest threshold, closed gain exactly one
    apply_cfg(32767, 0, 0, 0, 0, 65536);
    send_item(16'sd32767, 1'b1);
    send_item(-16'sd32768, 1'b0);
    send_item(16'sd5, 1'b0);
    send_item(16'sd0, 1'b1);
    send_item(-16'sd32768, 1'b0);
    send_item(16'sd32767, 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = flow_e'(ph % 4);
      case ($urandom_range(9))
        0: thr = 0;
        1: thr = 32767;
        2, 3: thr = $urandom_range(32767);
        default: thr = $urandom_range(3000);
      endcase
      case ($urandom_range(5))
        0: hyst = 0;
        1: hyst = 32767;
        2: hyst = $urandom_range(32767);
        default: hyst = $urandom_range(thr);
      endcase
      case ($urandom_range(7))
        0: atk = 65535;
        1: atk = 1;
        2: atk = 0;
        default: atk = $urandom_range(65535, 1);
      endcase
      case ($urandom_range(7))
        0: rel = 65535;
        1: rel = 1;
        2: rel = 0;
        default: rel = $urandom_range(65535, 1);
      endcase
      case ($urandom_range(9))
        0: hold = 65535;
        1, 2: hold = 0;
        default: hold = $urandom_range(40);
      endcase
      case ($urandom_range(7))
        0: cg = 0;
        1: cg = 65536;
        2: cg = $urandom_range(131071);
        3: cg = 131071;
        default: cg = $urandom_range(65536);
      endcase
      apply_cfg(thr, hyst, atk, rel, hold, cg);

      // segments of quiet, near-threshold and loud material open and close the gate
      seg_left = 0;
      loudness = 0;
      for (int k = 0; k < 119; k++) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(30, 1);
          loudness = $urandom_range(3);
        end
        seg_left--;
        case (loudness)
          0: amp = thr / 4;
          1: amp = thr;
          2: amp = (2 * thr + 1 > 32767) ? 32767 : 2 * thr + 1;
          default: amp = -1;
        endcase
        if (amp < 0 || $urandom_range(49) == 0) smp = SAMPLE_WIDTH'($urandom());
        else smp = SAMPLE_WIDTH'($urandom_range(2 * amp) - amp);
        send_item(smp, (k == 0) || ($urandom_range(39) == 0));
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("noise_gate_hysteresis_hold_top: match");
    end else begin
      $display("noise_gate_hysteresis_hold_top: mismatch");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("noise_gate_hysteresis_hold_top: mismatch");
    $finish;
  end

endmodule
